// ===== src/csem_pkg.sv =====
// Package for the counting semaphore table unit.
// Holds table sizes, field widths, status and ALU codes and the ALU request type.
// No dependencies.
package csem_pkg;

	// Table sizes
	localparam int NUM_SEMS       = 16;
	localparam int SLOTS_PER_PROC = 4;
	localparam int NUM_PROCS      = 64;

	// Derived widths
	localparam int SEM_W     = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
	localparam int SLOT_CW   = (SLOTS_PER_PROC > 1) ? $clog2(SLOTS_PER_PROC) : 1;
	localparam int SLOT_NUM  = NUM_PROCS * SLOTS_PER_PROC;
	localparam int SLOT_AW   = (SLOT_NUM > 1) ? $clog2(SLOT_NUM) : 1;

	// Field widths fixed by the item format
	localparam int TYPE_W    = 2;
	localparam int PROC_W    = 6;
	localparam int IDX_W     = 4;
	localparam int VAL_W     = 16;
	localparam int REF_W     = 9;
	localparam int STATUS_W  = 3;
	localparam int HANDLE_W  = 4;

	localparam logic [VAL_W-1:0] VALUE_MAX = {VAL_W{1'b1}};
	localparam logic [REF_W-1:0] REF_MAX   = {REF_W{1'b1}};

	// Request kinds
	localparam logic [TYPE_W-1:0] REQ_GET  = 2'd0;
	localparam logic [TYPE_W-1:0] REQ_FREE = 2'd1;
	localparam logic [TYPE_W-1:0] REQ_DOWN = 2'd2;
	localparam logic [TYPE_W-1:0] REQ_UP   = 2'd3;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_IN_USE  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_SLOTS_FULL  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_TABLE_FULL  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOT_HELD    = 3'd4;
	localparam logic [STATUS_W-1:0] ST_WOULD_BLOCK = 3'd5;

	// Shared ALU operations
	typedef enum logic [1:0] {
		ALU_PASS,
		ALU_INC,
		ALU_DEC,
		ALU_SATINC
	} alu_op_t;

	typedef struct packed {
		alu_op_t          op;
		logic [VAL_W-1:0] operand;
	} alu_req_t;

endpackage

// ===== src/csem_ram.sv =====
// Generic single write, single read RAM with registered read data.
// No dependencies.
module csem_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and register the read word
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== src/csem_alu.sv =====
// Shared increment / decrement unit for semaphore values and reference counts.
// Depends on csem_pkg.
module csem_alu
	import csem_pkg::*;
(
	input  alu_req_t         req,
	output logic [VAL_W-1:0] result,
	output logic             zero
);

	// One adder serves every count update
	always_comb begin
		case (req.op)
			ALU_INC:    result = req.operand + VAL_W'(1);
			ALU_DEC:    result = req.operand - VAL_W'(1);
			ALU_SATINC: result = (req.operand == VALUE_MAX) ? req.operand
			                                                : req.operand + VAL_W'(1);
			default:    result = req.operand;
		endcase
	end

	assign zero = (req.operand == '0);

endmodule

// ===== src/counting_semaphore_table_unit.sv =====
// Top level of the counting semaphore table unit: sequencer, semaphore tables,
// per-process slot valid bits and output register.
// Depends on csem_pkg, csem_alu and csem_ram.
//
//  channel | dir | signals                      | contents
//  --------+-----+------------------------------+-------------------------------------
//  s       | in  | s_tvalid s_tready s_tdata    | request item
//          |     | s_tuser                      | request kind and create flag
//  m       | out | m_tvalid m_tready m_tdata    | result item
//
//  Steps: after acceptance, create walks the semaphore table one entry a cycle and
//  then the process slots one a cycle; join checks the entry and then walks the slots,
//  free checks the entry and then reads and compares each slot (RAM read then compare),
//  down and up take the check alone. The result is registered on m as the sequencer finishes.
//  Reset clears all counts and slot valid bits at once; no sweep is needed.
//  A result waiting on m stalls only the final step of the next request.
module counting_semaphore_table_unit
	import csem_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // proc_id[5:0], sem_index[9:6], start_count[25:10], zero
	input  logic [2:0]  s_tuser,  // req_type[1:0], create_new[2]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata   // status[2:0], sem_handle[6:3], wake_waiters[7]
);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_CHECK    = 3'd1;
	localparam logic [2:0] S_SEM_SCAN = 3'd2;
	localparam logic [2:0] S_SLOT_SCN = 3'd3;
	localparam logic [2:0] S_SLOT_RD  = 3'd4;
	localparam logic [2:0] S_SLOT_CMP = 3'd5;

	// Sequencer and request registers
	logic [2:0]          state_q, nxt_state;
	logic [TYPE_W-1:0]   type_q;
	logic [PROC_W-1:0]   proc_q;
	logic                create_q;
	logic [IDX_W-1:0]    idx_q;
	logic [VAL_W-1:0]    init_q;
	logic [SEM_W-1:0]    target_q, nxt_target;
	logic [SEM_W-1:0]    sem_cnt_q, nxt_sem_cnt;
	logic [SLOT_CW-1:0]  slot_cnt_q, nxt_slot_cnt;

	// Tables
	logic [VAL_W-1:0]    val_q [NUM_SEMS];
	logic [REF_W-1:0]    ref_q [NUM_SEMS];
	logic [SLOT_NUM-1:0] slot_vld_q;

	// Output register
	logic                out_valid_q;
	logic [7:0]          out_data_q;

	// Step controls
	logic                fin, commit, out_free, accept;
	logic [STATUS_W-1:0] fin_status;
	logic [HANDLE_W-1:0] fin_handle;
	logic                fin_wake;
	logic                val_we, ref_we, slot_set, slot_clr;
	logic [VAL_W-1:0]    val_wd;
	logic [REF_W-1:0]    ref_wd;

	logic [SEM_W-1:0]    rd_sem;
	logic [REF_W-1:0]    ref_rd;
	logic [VAL_W-1:0]    val_rd;
	logic [SLOT_AW-1:0]  slot_addr;
	logic                slot_vld;
	logic [SEM_W-1:0]    slot_sem;
	logic                proc_ok, idx_ok, sem_last, slot_last;

	alu_req_t            alu_req;
	logic [VAL_W-1:0]    alu_res;
	logic                alu_zero;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || m_tready;
	assign commit   = !fin || out_free;

	assign rd_sem    = (state_q == S_SEM_SCAN) ? sem_cnt_q : target_q;
	assign ref_rd    = ref_q[rd_sem];
	assign val_rd    = val_q[target_q];
	assign slot_addr = SLOT_AW'(int'(proc_q) * SLOTS_PER_PROC + int'(slot_cnt_q));
	assign slot_vld  = slot_vld_q[slot_addr];
	assign proc_ok   = (int'(proc_q) < NUM_PROCS);
	assign idx_ok    = (int'(idx_q) < NUM_SEMS);
	assign sem_last  = (sem_cnt_q == SEM_W'(NUM_SEMS - 1));
	assign slot_last = (slot_cnt_q == SLOT_CW'(SLOTS_PER_PROC - 1));

	csem_alu u_alu (
		.req    (alu_req),
		.result (alu_res),
		.zero   (alu_zero)
	);

	// Semaphore index of each held slot; valid bits live in flops
	csem_ram #(
		.WIDTH (SEM_W),
		.DEPTH (SLOT_NUM)
	) u_slot_ram (
		.clk     (clk),
		.wr_en   (slot_set && commit),
		.wr_addr (slot_addr),
		.wr_data (target_q),
		.rd_addr (slot_addr),
		.rd_data (slot_sem)
	);

	// Select the ALU operand for the current step
	always_comb begin
		alu_req.op      = ALU_PASS;
		alu_req.operand = {{(VAL_W-REF_W){1'b0}}, ref_rd};
		case (state_q)
			S_CHECK: begin
				alu_req.operand = val_rd;
				alu_req.op      = (type_q == REQ_UP) ? ALU_SATINC : ALU_DEC;
			end
			S_SLOT_SCN: alu_req.op = ALU_INC;
			S_SLOT_CMP: alu_req.op = ALU_DEC;
			default:    alu_req.op = ALU_PASS;
		endcase
	end

	// Sequencer step
	always_comb begin
		nxt_state    = state_q;
		nxt_target   = target_q;
		nxt_sem_cnt  = sem_cnt_q;
		nxt_slot_cnt = slot_cnt_q;
		fin          = 1'b0;
		fin_status   = ST_OK;
		fin_handle   = '0;
		fin_wake     = 1'b0;
		val_we       = 1'b0;
		val_wd       = alu_res;
		ref_we       = 1'b0;
		ref_wd       = alu_res[REF_W-1:0];
		slot_set     = 1'b0;
		slot_clr     = 1'b0;
		case (state_q)
			S_CHECK: begin
				if (!idx_ok || ref_rd == '0) begin
					fin        = 1'b1;
					fin_status = ST_NOT_IN_USE;
				end else begin
					case (type_q)
						REQ_GET: begin
							if (proc_ok) begin
								nxt_state    = S_SLOT_SCN;
								nxt_slot_cnt = '0;
							end else begin
								fin        = 1'b1;
								fin_status = ST_SLOTS_FULL;
							end
						end
						REQ_FREE: begin
							if (proc_ok) begin
								nxt_state    = S_SLOT_RD;
								nxt_slot_cnt = '0;
							end else begin
								fin        = 1'b1;
								fin_status = ST_NOT_HELD;
							end
						end
						REQ_DOWN: begin
							fin = 1'b1;
							if (alu_zero) begin
								fin_status = ST_WOULD_BLOCK;
							end else begin
								val_we = 1'b1;
							end
						end
						default: begin
							fin      = 1'b1;
							fin_wake = alu_zero;
							val_we   = 1'b1;
						end
					endcase
				end
			end
			S_SEM_SCAN: begin
				if (ref_rd == '0) begin
					nxt_target = sem_cnt_q;
					if (proc_ok) begin
						nxt_state    = S_SLOT_SCN;
						nxt_slot_cnt = '0;
					end else begin
						fin        = 1'b1;
						fin_status = ST_SLOTS_FULL;
					end
				end else if (sem_last) begin
					fin        = 1'b1;
					fin_status = ST_TABLE_FULL;
				end else begin
					nxt_sem_cnt = sem_cnt_q + SEM_W'(1);
				end
			end
			S_SLOT_SCN: begin
				if (!slot_vld) begin
					fin = 1'b1;
					if (create_q) begin
						val_we     = 1'b1;
						val_wd     = init_q;
						ref_we     = 1'b1;
						ref_wd     = REF_W'(1);
						slot_set   = 1'b1;
						fin_handle = HANDLE_W'(target_q);
					end else if (ref_rd >= REF_MAX) begin
						fin_status = ST_TABLE_FULL;
					end else begin
						ref_we     = 1'b1;
						slot_set   = 1'b1;
						fin_handle = HANDLE_W'(target_q);
					end
				end else if (slot_last) begin
					fin        = 1'b1;
					fin_status = ST_SLOTS_FULL;
				end else begin
					nxt_slot_cnt = slot_cnt_q + SLOT_CW'(1);
				end
			end
			S_SLOT_RD: nxt_state = S_SLOT_CMP;
			S_SLOT_CMP: begin
				if (slot_vld && slot_sem == target_q) begin
					fin      = 1'b1;
					slot_clr = 1'b1;
					ref_we   = 1'b1;
				end else if (slot_last) begin
					fin        = 1'b1;
					fin_status = ST_NOT_HELD;
				end else begin
					nxt_state    = S_SLOT_RD;
					nxt_slot_cnt = slot_cnt_q + SLOT_CW'(1);
				end
			end
			default: nxt_state = state_q;
		endcase
		if (fin) begin
			nxt_state = S_IDLE;
		end
	end

	// Latch the request and advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			sem_cnt_q  <= '0;
			slot_cnt_q <= '0;
			target_q   <= '0;
		end else if (state_q == S_IDLE) begin
			if (accept) begin
				sem_cnt_q <= '0;
				target_q  <= SEM_W'(s_tdata[9:6]);
				if (s_tuser[1:0] == REQ_GET && s_tuser[2]) begin
					state_q <= S_SEM_SCAN;
				end else begin
					state_q <= S_CHECK;
				end
			end
		end else if (commit) begin
			state_q    <= nxt_state;
			sem_cnt_q  <= nxt_sem_cnt;
			slot_cnt_q <= nxt_slot_cnt;
			target_q   <= nxt_target;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			type_q   <= s_tuser[1:0];
			create_q <= s_tuser[2];
			proc_q   <= s_tdata[5:0];
			idx_q    <= s_tdata[9:6];
			init_q   <= s_tdata[25:10];
		end
	end

	// Update semaphore tables and slot valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SEMS; i++) begin
				val_q[i] <= '0;
				ref_q[i] <= '0;
			end
			slot_vld_q <= '0;
		end else if (state_q != S_IDLE && commit) begin
			if (val_we) begin
				val_q[target_q] <= val_wd;
			end
			if (ref_we) begin
				ref_q[target_q] <= ref_wd;
			end
			if (slot_set) begin
				slot_vld_q[slot_addr] <= 1'b1;
			end
			if (slot_clr) begin
				slot_vld_q[slot_addr] <= 1'b0;
			end
		end
	end

	// Load the result register, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q != S_IDLE && fin && commit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q != S_IDLE && fin && commit) begin
			out_data_q <= {fin_wake, fin_handle, fin_status};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// A new result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE && fin && commit) |-> (!out_valid_q || m_tready))
		else $error("result register overwritten while pending");

	// An accepted item always starts the sequencer
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_CHECK || state_q == S_SEM_SCAN))
		else $error("accepted item did not start the sequencer");

	// A reference is dropped only from a semaphore that is in use
	a_ref_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SLOT_CMP && slot_clr && commit) |-> (ref_rd != '0))
		else $error("reference count underflow");

	// A filled slot shows as held on the next cycle
	a_slot_set: assert property (@(posedge clk) disable iff (!arst_n)
		(slot_set && commit) |=> slot_vld_q[$past(slot_addr)])
		else $error("slot valid bit not set");

endmodule

// ===== sim/counting_semaphore_table_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for counting_semaphore_table_unit: directed table, then
// random request traffic checked against an in-bench semaphore table predictor.
// Depends on csem_pkg and the counting_semaphore_table_unit RTL.
module counting_semaphore_table_unit_tb;
	import csem_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 1500;
	localparam int HOLD_CYCLES  = 300;
	localparam int HOLD_AFTER   = 400;
	localparam int ERROR_CAP    = 200;

	typedef struct {
		logic [TYPE_W-1:0] kind;
		logic [PROC_W-1:0] proc;
		logic              create;
		logic [IDX_W-1:0]  idx;
		logic [VAL_W-1:0]  init;
	} sem_req_t;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [HANDLE_W-1:0] handle;
		logic                wake;
	} sem_res_t;

	typedef struct {
		bit       typed;
		sem_res_t res;
	} typed_tag_t;

	typedef struct {
		sem_req_t req;
		int       reps;
		bit       typed;
		sem_res_t res;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;  // proc_id[5:0], sem_index[9:6], start_count[25:10], zero
	logic [2:0]  s_tuser;  // req_type[1:0], create_new[2]
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;  // status[2:0], sem_handle[6:3], wake_waiters[7]

	// Predictor state: semaphore values, reference counts, per-process slots
	logic [VAL_W-1:0] sem_count[NUM_SEMS];
	logic [REF_W-1:0] sem_refs[NUM_SEMS];
	bit               slot_held[NUM_PROCS][SLOTS_PER_PROC];
	logic [IDX_W-1:0] slot_sem[NUM_PROCS][SLOTS_PER_PROC];

	sem_res_t   pending_results[$];
	typed_tag_t typed_tags[$];
	stim_row_t  directed_rows[$];

	int  mismatches;
	int  results_seen;
	int  cycle_count;
	bit  no_idle;

	counting_semaphore_table_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Return the first empty slot of a process, or -1 when all are taken
	function automatic int open_slot(logic [PROC_W-1:0] proc);
		for (int k = 0; k < SLOTS_PER_PROC; k++) begin
			if (!slot_held[proc][k]) begin
				return k;
			end
		end
		return -1;
	endfunction

	// Apply one request to the semaphore table and return its outcome
	function automatic sem_res_t semaphore_outcome(sem_req_t r);
		sem_res_t o;
		int       free_sem;
		int       slot;
		bit       in_use;
		o.status = ST_OK;
		o.handle = '0;
		o.wake   = 1'b0;
		in_use   = (sem_refs[r.idx] != '0);
		case (r.kind)
			REQ_GET: begin
				slot = open_slot(r.proc);
				if (r.create) begin
					free_sem = -1;
					for (int s = NUM_SEMS - 1; s >= 0; s--) begin
						if (sem_refs[s] == '0) free_sem = s;
					end
					if (free_sem < 0) begin
						o.status = ST_TABLE_FULL;
					end else if (slot < 0) begin
						o.status = ST_SLOTS_FULL;
					end else begin
						sem_count[free_sem]     = r.init;
						sem_refs[free_sem]      = REF_W'(1);
						slot_held[r.proc][slot] = 1'b1;
						slot_sem[r.proc][slot]  = IDX_W'(free_sem);
						o.handle                = HANDLE_W'(free_sem);
					end
				end else if (!in_use) begin
					o.status = ST_NOT_IN_USE;
				end else if (slot < 0) begin
					o.status = ST_SLOTS_FULL;
				end else if (sem_refs[r.idx] == REF_MAX) begin
					o.status = ST_TABLE_FULL;
				end else begin
					slot_held[r.proc][slot] = 1'b1;
					slot_sem[r.proc][slot]  = r.idx;
					sem_refs[r.idx]         = sem_refs[r.idx] + 1'b1;
					o.handle                = r.idx;
				end
			end
			REQ_FREE: begin
				if (!in_use) begin
					o.status = ST_NOT_IN_USE;
				end else begin
					o.status = ST_NOT_HELD;
					for (int k = 0; k < SLOTS_PER_PROC; k++) begin
						if (o.status == ST_NOT_HELD && slot_held[r.proc][k] &&
						    slot_sem[r.proc][k] == r.idx) begin
							slot_held[r.proc][k] = 1'b0;
							slot_sem[r.proc][k]  = '0;
							sem_refs[r.idx]      = sem_refs[r.idx] - 1'b1;
							o.status             = ST_OK;
						end
					end
				end
			end
			REQ_DOWN: begin
				if (!in_use) begin
					o.status = ST_NOT_IN_USE;
				end else if (sem_count[r.idx] == '0) begin
					o.status = ST_WOULD_BLOCK;
				end else begin
					sem_count[r.idx] = sem_count[r.idx] - 1'b1;
				end
			end
			default: begin
				if (!in_use) begin
					o.status = ST_NOT_IN_USE;
				end else begin
					o.wake = (sem_count[r.idx] == '0);
					if (sem_count[r.idx] != VALUE_MAX) begin
						sem_count[r.idx] = sem_count[r.idx] + 1'b1;
					end
				end
			end
		endcase
		return o;
	endfunction

	// Pick a semaphore that is in use most of the time, any index otherwise
	function automatic logic [IDX_W-1:0] live_sem();
		int live[$];
		for (int s = 0; s < NUM_SEMS; s++) begin
			if (sem_refs[s] != '0) live.push_back(s);
		end
		if (live.size() == 0 || $urandom_range(0, 99) < 15) begin
			return IDX_W'($urandom_range(0, NUM_SEMS - 1));
		end
		return IDX_W'(live[$urandom_range(0, live.size() - 1)]);
	endfunction

	// Return a semaphore that the process holds, or -1 when it holds none
	function automatic int held_sem(logic [PROC_W-1:0] proc);
		int held[$];
		for (int k = 0; k < SLOTS_PER_PROC; k++) begin
			if (slot_held[proc][k]) held.push_back(int'(slot_sem[proc][k]));
		end
		if (held.size() == 0) begin
			return -1;
		end
		return held[$urandom_range(0, held.size() - 1)];
	endfunction

	// Draw a request; filling phases favor create and join, draining ones free
	function automatic sem_req_t random_request(bit filling);
		sem_req_t r;
		int       pick;
		int       held;
		r.proc   = ($urandom_range(0, 9) < 7) ? PROC_W'($urandom_range(0, 7))
		                                      : PROC_W'($urandom_range(0, NUM_PROCS - 1));
		r.create = 1'($urandom_range(0, 1));
		r.idx    = live_sem();
		case ($urandom_range(0, 3))
			0:       r.init = VAL_W'($urandom_range(0, 2));
			1:       r.init = VALUE_MAX - VAL_W'($urandom_range(0, 2));
			default: r.init = VAL_W'($urandom);
		endcase
		pick = $urandom_range(0, 99);
		if (pick < (filling ? 30 : 10)) begin
			r.kind   = REQ_GET;
			r.create = 1'b1;
		end else if (pick < (filling ? 50 : 25)) begin
			r.kind   = REQ_GET;
			r.create = 1'b0;
		end else if (pick < (filling ? 62 : 60)) begin
			r.kind = REQ_FREE;
			held   = held_sem(r.proc);
			if (held >= 0 && $urandom_range(0, 3) != 0) r.idx = IDX_W'(held);
		end else if (pick < 80) begin
			r.kind = REQ_DOWN;
		end else begin
			r.kind = REQ_UP;
		end
		return r;
	endfunction

	function automatic stim_row_t stim(logic [TYPE_W-1:0] kind, int proc, int create, int idx,
	                                   int init, int reps, int typed,
	                                   logic [STATUS_W-1:0] status, int handle, int wake);
		stim_row_t row;
		row.req.kind   = kind;
		row.req.proc   = PROC_W'(proc);
		row.req.create = 1'(create);
		row.req.idx    = IDX_W'(idx);
		row.req.init   = VAL_W'(init);
		row.reps       = reps;
		row.typed      = 1'(typed);
		row.res.status = status;
		row.res.handle = HANDLE_W'(handle);
		row.res.wake   = 1'(wake);
		return row;
	endfunction

	// Offer one request item, after a random gap unless no_idle is set, and hold it until accepted
	task automatic offer(sem_req_t r, bit typed, sem_res_t res);
		typed_tag_t tag;
		int         gap;
		gap = no_idle ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		tag.typed = typed;
		tag.res   = res;
		typed_tags.push_back(tag);
		s_tvalid <= 1'b1;
		s_tdata  <= {6'b0, r.init, r.idx, r.proc};
		s_tuser  <= {r.create, r.kind};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// Predict on each accepted request, compare each accepted result
	always @(posedge clk) begin
		sem_req_t   rq;
		sem_res_t   want;
		typed_tag_t tag;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= ERROR_CAP)
					$error("unexpected result item: %h", m_tdata);
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[2:0] !== want.status) begin
					mismatches++;
					if (mismatches <= ERROR_CAP)
						$error("status: expected %0d, got %0d", want.status, m_tdata[2:0]);
				end
				if (m_tdata[6:3] !== want.handle) begin
					mismatches++;
					if (mismatches <= ERROR_CAP)
						$error("sem_handle: expected %0d, got %0d", want.handle, m_tdata[6:3]);
				end
				if (m_tdata[7] !== want.wake) begin
					mismatches++;
					if (mismatches <= ERROR_CAP)
						$error("wake_waiters: expected %0d, got %0d", want.wake, m_tdata[7]);
				end
			end
		end
		if (arst_n && s_tvalid && s_tready) begin
			rq.proc   = s_tdata[5:0];
			rq.idx    = s_tdata[9:6];
			rq.init   = s_tdata[25:10];
			rq.kind   = s_tuser[1:0];
			rq.create = s_tuser[2];
			want      = semaphore_outcome(rq);
			tag       = typed_tags.pop_front();
			pending_results.push_back(tag.typed ? tag.res : want);
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL counting_semaphore_table_unit");
			$finish;
		end
	end

	// Result side: random stalls, one long hold-off to back up the block
	initial begin
		int  stall;
		bit  held_off;
		held_off = 1'b0;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (!held_off && results_seen >= HOLD_AFTER) begin
				held_off = 1'b1;
				stall    = HOLD_CYCLES;
			end else begin
				stall = no_idle ? 0 : $urandom_range(0, 9);
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	// Reset, directed table, random traffic, drain and verdict
	initial begin
		sem_res_t none;
		sem_req_t rq;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = '0;
		arst_n      = 1'b0;
		mismatches  = 0;
		results_seen = 0;
		cycle_count = 0;
		no_idle     = 1'b0;
		none.status = ST_OK;
		none.handle = '0;
		none.wake   = 1'b0;
		for (int s = 0; s < NUM_SEMS; s++) begin
			sem_count[s] = '0;
			sem_refs[s]  = '0;
		end
		for (int p = 0; p < NUM_PROCS; p++) begin
			for (int k = 0; k < SLOTS_PER_PROC; k++) begin
				slot_held[p][k] = 1'b0;
				slot_sem[p][k]  = '0;
			end
		end

		// Requests on an empty table, then creation, wake, saturation and limits
		directed_rows.push_back(stim(REQ_DOWN, 0,  0, 3,  0,      1, 1, ST_NOT_IN_USE,  0, 0));
		directed_rows.push_back(stim(REQ_GET,  0,  0, 7,  0,      1, 1, ST_NOT_IN_USE,  0, 0));
		directed_rows.push_back(stim(REQ_FREE, 0,  0, 0,  0,      1, 1, ST_NOT_IN_USE,  0, 0));
		directed_rows.push_back(stim(REQ_GET,  0,  1, 0,  'hFFFF, 1, 1, ST_OK,          0, 0));
		directed_rows.push_back(stim(REQ_UP,   0,  0, 0,  0,      1, 1, ST_OK,          0, 0));
		directed_rows.push_back(stim(REQ_GET,  0,  1, 9,  0,      1, 1, ST_OK,          1, 0));
		directed_rows.push_back(stim(REQ_DOWN, 63, 1, 1,  0,      1, 1, ST_WOULD_BLOCK, 0, 0));
		directed_rows.push_back(stim(REQ_UP,   63, 0, 1,  0,      1, 1, ST_OK,          0, 1));
		directed_rows.push_back(stim(REQ_GET,  0,  0, 1,  0,      1, 1, ST_OK,          1, 0));
		directed_rows.push_back(stim(REQ_GET,  0,  1, 15, 7,      1, 1, ST_OK,          2, 0));
		directed_rows.push_back(stim(REQ_GET,  0,  1, 0,  5,      1, 1, ST_SLOTS_FULL,  0, 0));
		directed_rows.push_back(stim(REQ_FREE, 63, 0, 0,  0,      1, 1, ST_NOT_HELD,    0, 0));
		// Fill the rest of the table, one creating process each
		directed_rows.push_back(stim(REQ_GET,  1,  1, 0,  'hA5A5, 13, 0, ST_OK,         0, 0));
		directed_rows.push_back(stim(REQ_GET,  63, 1, 0,  'h5A5A, 1, 1, ST_TABLE_FULL,  0, 0));
		directed_rows.push_back(stim(REQ_FREE, 0,  0, 1,  0,      1, 1, ST_OK,          0, 0));

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			for (int n = 0; n < directed_rows[i].reps; n++) begin
				rq      = directed_rows[i].req;
				rq.proc = rq.proc + PROC_W'(n);
				offer(rq, directed_rows[i].typed, directed_rows[i].res);
			end
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 150 == 0) no_idle = ($urandom_range(0, 3) == 0);
			offer(random_request(((n / 250) % 2) == 0), 1'b0, none);
		end
		s_tvalid <= 1'b0;
		no_idle = 1'b0;

		// Drain, then leave room for anything stray
		while (pending_results.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (mismatches == 0) begin
			$display("PASS counting_semaphore_table_unit");
		end else begin
			$display("FAIL counting_semaphore_table_unit");
		end
		$finish;
	end

endmodule

// ===== files.f =====
src/csem_pkg.sv
src/csem_ram.sv
src/csem_alu.sv
src/counting_semaphore_table_unit.sv
sim/counting_semaphore_table_unit_tb.sv
